// ----- design/mru_handle_ring_table_macros.svh -----
// assertion macros for the handle ring table
`ifndef MRU_HANDLE_RING_TABLE_MACROS_SVH
`define MRU_HANDLE_RING_TABLE_MACROS_SVH

`ifndef SYNTHESIS
`define MHRT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mhrt assertion failed");
`define MHRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mhrt assertion failed");
`else
`define MHRT_ASSERT_SAME(label, ante, cons)
`define MHRT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- design/mhrt_pkg.sv -----
// shared types and constants of the handle ring table
package mhrt_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int OP_W      = 2;
    localparam int POS_W     = 6;
    localparam int HANDLE_W  = 32;
    localparam int OWNER_W   = 16;
    localparam int KIND_W    = 3;
    localparam int SLOT_W    = HANDLE_W + OWNER_W;

    typedef enum logic [OP_W-1:0] {
        OP_GET    = 2'd0,
        OP_PUSH   = 2'd1,
        OP_MOVE   = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_HANDLE   = 3'd0,
        KIND_PLACED   = 3'd1,
        KIND_UNLOADED = 3'd2,
        KIND_ERROR    = 3'd3,
        KIND_ACK      = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PUSH_PLACE,
        ST_RM_ACK,
        ST_MV_SHIFT,
        ST_MV_LAST,
        ST_MV_REPLY
    } state_t;

    typedef struct packed {
        logic                valid;
        kind_t               kind;
        logic [OWNER_W-1:0]  owner;
        logic [POS_W-1:0]    index;
        logic [HANDLE_W-1:0] handle;
        logic                last;
    } emit_t;

endpackage

// ----- design/mhrt_req_if.sv -----
// request channel interface
interface mhrt_req_if;
    logic                         valid;
    logic                         ready;
    logic [mhrt_pkg::OP_W-1:0]    operation;
    logic [mhrt_pkg::POS_W-1:0]   position;
    logic [mhrt_pkg::HANDLE_W-1:0] handle_in;
    logic [mhrt_pkg::OWNER_W-1:0] owner_tag;

    modport source (output valid, operation, position, handle_in, owner_tag, input ready);
    modport sink (input valid, operation, position, handle_in, owner_tag, output ready);
endinterface

// ----- design/mhrt_rsp_if.sv -----
// response channel interface
interface mhrt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [mhrt_pkg::KIND_W-1:0]   kind;
    logic [mhrt_pkg::OWNER_W-1:0]  owner_out;
    logic [mhrt_pkg::POS_W-1:0]    index_out;
    logic [mhrt_pkg::HANDLE_W-1:0] handle_out;
    logic                          last;

    modport source (output valid, kind, owner_out, index_out, handle_out, last, input ready);
    modport sink (input valid, kind, owner_out, index_out, handle_out, last, output ready);
endinterface

// ----- design/mhrt_ram.sv -----
// generic simple dual-port ram with registered read
module mhrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/mhrt_ctrl.sv -----
// sequencer: read-modify-write of the slot ram, valid bits and newest pointer
module mhrt_ctrl #(
    parameter int DEPTH = mhrt_pkg::DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    mhrt_req_if.sink                    req,
    input  logic                        out_free,
    output mhrt_pkg::emit_t             emit,
    output logic                        busy,
    output logic                        wr_en,
    output logic [$clog2(DEPTH)-1:0]    wr_addr,
    output logic [mhrt_pkg::SLOT_W-1:0] wr_data,
    output logic                        rd_en,
    output logic [$clog2(DEPTH)-1:0]    rd_addr,
    input  logic [mhrt_pkg::SLOT_W-1:0] rd_data
);

    localparam int IW = $clog2(DEPTH);

    function automatic logic [IW-1:0] wrap(input logic [IW-1:0] i);
        logic [IW-1:0] r;
        r = (i == IW'(DEPTH - 1)) ? '0 : IW'(i + 1'b1);
        return r;
    endfunction

    mhrt_pkg::state_t state_reg, state_next;

    mhrt_pkg::op_t                 op_reg;
    logic [mhrt_pkg::POS_W-1:0]    pos_reg;
    logic [mhrt_pkg::HANDLE_W-1:0] hin_reg;
    logic [mhrt_pkg::OWNER_W-1:0]  own_reg;
    logic [mhrt_pkg::HANDLE_W-1:0] sh_reg;
    logic [mhrt_pkg::OWNER_W-1:0]  so_reg;
    logic                          sv_reg;
    logic                          save_en;

    logic [IW-1:0]    newest_reg, newest_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [DEPTH-1:0] valid_reg, valid_next;

    logic                          accept;
    logic [IW-1:0]                 a_idx;
    logic [IW-1:0]                 np;
    logic [IW-1:0]                 nx;
    logic                          pos_bad;
    logic                          pv;
    logic                          push_v;
    logic                          nx_v;
    logic                          mv_same;
    logic                          exec_need;
    logic                          exec_go;
    logic                          shift_go;
    logic                          last_go;
    logic [mhrt_pkg::HANDLE_W-1:0] rd_handle;
    logic [mhrt_pkg::OWNER_W-1:0]  rd_owner;

    assign req.ready = (state_reg == mhrt_pkg::ST_IDLE);
    assign busy      = (state_reg != mhrt_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;

    assign a_idx     = pos_reg[IW-1:0];
    assign np        = wrap(newest_reg);
    assign nx        = wrap(idx_reg);
    assign pos_bad   = (op_reg != mhrt_pkg::OP_PUSH) &&
                       (pos_reg >= mhrt_pkg::POS_W'(DEPTH));
    assign pv        = valid_reg[a_idx];
    assign push_v    = valid_reg[np];
    assign nx_v      = valid_reg[nx];
    assign mv_same   = (a_idx == newest_reg);
    assign rd_handle = rd_data[mhrt_pkg::SLOT_W-1 -: mhrt_pkg::HANDLE_W];
    assign rd_owner  = rd_data[mhrt_pkg::OWNER_W-1:0];

    always_comb
    begin
        exec_need = 1'b1;
        if (!pos_bad)
        begin
            case (op_reg)
                mhrt_pkg::OP_GET:    exec_need = 1'b1;
                mhrt_pkg::OP_PUSH:   exec_need = push_v;
                mhrt_pkg::OP_REMOVE: exec_need = pv;
                mhrt_pkg::OP_MOVE:   exec_need = mv_same;
                default:             exec_need = 1'b1;
            endcase
        end
    end

    assign exec_go  = !exec_need || out_free;
    assign shift_go = !nx_v || out_free;
    assign last_go  = !sv_reg || out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mhrt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = mhrt_pkg::ST_EXEC;
                end
            end
            mhrt_pkg::ST_EXEC:
            begin
                if (exec_go)
                begin
                    if (pos_bad)
                    begin
                        state_next = mhrt_pkg::ST_IDLE;
                    end
                    else
                    begin
                        case (op_reg)
                            mhrt_pkg::OP_GET:    state_next = mhrt_pkg::ST_IDLE;
                            mhrt_pkg::OP_PUSH:   state_next = mhrt_pkg::ST_PUSH_PLACE;
                            mhrt_pkg::OP_REMOVE: state_next = mhrt_pkg::ST_RM_ACK;
                            mhrt_pkg::OP_MOVE:
                                state_next = mv_same ? mhrt_pkg::ST_IDLE
                                                     : mhrt_pkg::ST_MV_SHIFT;
                            default:             state_next = mhrt_pkg::ST_IDLE;
                        endcase
                    end
                end
            end
            mhrt_pkg::ST_PUSH_PLACE,
            mhrt_pkg::ST_RM_ACK,
            mhrt_pkg::ST_MV_REPLY:
            begin
                if (out_free)
                begin
                    state_next = mhrt_pkg::ST_IDLE;
                end
            end
            mhrt_pkg::ST_MV_SHIFT:
            begin
                if (shift_go && (nx == newest_reg))
                begin
                    state_next = mhrt_pkg::ST_MV_LAST;
                end
            end
            mhrt_pkg::ST_MV_LAST:
            begin
                if (last_go)
                begin
                    state_next = mhrt_pkg::ST_MV_REPLY;
                end
            end
            default:
            begin
                state_next = mhrt_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        emit        = '0;
        emit.kind   = mhrt_pkg::KIND_HANDLE;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        save_en     = 1'b0;
        newest_next = newest_reg;
        idx_next    = idx_reg;
        valid_next  = valid_reg;
        case (state_reg)
            mhrt_pkg::ST_IDLE:
            begin
                if (mhrt_pkg::op_t'(req.operation) == mhrt_pkg::OP_PUSH)
                begin
                    rd_addr = np;
                    rd_en   = accept;
                end
                else
                begin
                    rd_addr = req.position[IW-1:0];
                    rd_en   = accept && (req.position < mhrt_pkg::POS_W'(DEPTH));
                end
            end
            mhrt_pkg::ST_EXEC:
            begin
                if (pos_bad)
                begin
                    emit.valid = out_free;
                    emit.kind  = mhrt_pkg::KIND_ERROR;
                    emit.last  = 1'b1;
                end
                else
                begin
                    case (op_reg)
                        mhrt_pkg::OP_GET:
                        begin
                            emit.valid  = out_free;
                            emit.kind   = mhrt_pkg::KIND_HANDLE;
                            emit.handle = pv ? rd_handle : '0;
                            emit.last   = 1'b1;
                        end
                        mhrt_pkg::OP_PUSH:
                        begin
                            emit.valid = push_v && out_free;
                            emit.kind  = mhrt_pkg::KIND_UNLOADED;
                            emit.owner = rd_owner;
                        end
                        mhrt_pkg::OP_REMOVE:
                        begin
                            emit.valid = pv && out_free;
                            emit.kind  = mhrt_pkg::KIND_UNLOADED;
                            emit.owner = rd_owner;
                        end
                        mhrt_pkg::OP_MOVE:
                        begin
                            if (mv_same)
                            begin
                                emit.valid  = out_free;
                                emit.kind   = mhrt_pkg::KIND_HANDLE;
                                emit.handle = pv ? rd_handle : '0;
                                emit.last   = 1'b1;
                            end
                            else
                            begin
                                save_en  = 1'b1;
                                idx_next = a_idx;
                                rd_en    = 1'b1;
                                rd_addr  = wrap(a_idx);
                            end
                        end
                        default:
                        begin
                            emit.valid = 1'b0;
                        end
                    endcase
                end
            end
            mhrt_pkg::ST_PUSH_PLACE:
            begin
                if (out_free)
                begin
                    wr_en           = 1'b1;
                    wr_addr         = np;
                    wr_data         = {hin_reg, own_reg};
                    valid_next[np]  = 1'b1;
                    newest_next     = np;
                    emit.valid      = 1'b1;
                    emit.kind       = mhrt_pkg::KIND_PLACED;
                    emit.owner      = own_reg;
                    emit.index      = mhrt_pkg::POS_W'(np);
                    emit.last       = 1'b1;
                end
            end
            mhrt_pkg::ST_RM_ACK:
            begin
                if (out_free)
                begin
                    valid_next[a_idx] = 1'b0;
                    emit.valid        = 1'b1;
                    emit.kind         = mhrt_pkg::KIND_ACK;
                    emit.last         = 1'b1;
                end
            end
            mhrt_pkg::ST_MV_SHIFT:
            begin
                if (shift_go)
                begin
                    wr_en               = 1'b1;
                    wr_addr             = idx_reg;
                    wr_data             = rd_data;
                    valid_next[idx_reg] = nx_v;
                    emit.valid          = nx_v;
                    emit.kind           = mhrt_pkg::KIND_PLACED;
                    emit.owner          = rd_owner;
                    emit.index          = mhrt_pkg::POS_W'(idx_reg);
                    idx_next            = nx;
                    if (nx != newest_reg)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = wrap(nx);
                    end
                end
            end
            mhrt_pkg::ST_MV_LAST:
            begin
                if (last_go)
                begin
                    wr_en                  = 1'b1;
                    wr_addr                = newest_reg;
                    wr_data                = {sh_reg, so_reg};
                    valid_next[newest_reg] = sv_reg;
                    emit.valid             = sv_reg;
                    emit.kind              = mhrt_pkg::KIND_PLACED;
                    emit.owner             = so_reg;
                    emit.index             = mhrt_pkg::POS_W'(newest_reg);
                end
            end
            mhrt_pkg::ST_MV_REPLY:
            begin
                emit.valid  = out_free;
                emit.kind   = mhrt_pkg::KIND_HANDLE;
                emit.handle = sv_reg ? sh_reg : '0;
                emit.last   = 1'b1;
            end
            default:
            begin
                emit.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mhrt_pkg::ST_IDLE;
            newest_reg <= IW'(DEPTH - 1);
            valid_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            newest_reg <= newest_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (accept)
        begin
            op_reg  <= mhrt_pkg::op_t'(req.operation);
            pos_reg <= req.position;
            hin_reg <= req.handle_in;
            own_reg <= req.owner_tag;
        end
        if (save_en)
        begin
            sh_reg <= pv ? rd_handle : '0;
            so_reg <= rd_owner;
            sv_reg <= pv;
        end
    end

endmodule

// ----- design/mru_handle_ring_table.sv -----
// handle ring table: move-to-front ring of handles with owner reports
// results leave through a registered output; a new request is taken only when idle,
// after the last result of the previous request has been emitted
// a move shifts one slot per cycle through the single ram read port while rsp is not stalled
// reset: all slots empty, newest position DEPTH-1; no clearing pass is needed
`include "mru_handle_ring_table_macros.svh"

module mru_handle_ring_table #(
    parameter int DEPTH = mhrt_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    mhrt_req_if.sink    req,
    mhrt_rsp_if.source  rsp
);

    localparam int IW = $clog2(DEPTH);

    mhrt_pkg::emit_t emit;
    logic            busy;
    logic            out_free;

    logic                          wr_en;
    logic [IW-1:0]                 wr_addr;
    logic [mhrt_pkg::SLOT_W-1:0]   wr_data;
    logic                          rd_en;
    logic [IW-1:0]                 rd_addr;
    logic [mhrt_pkg::SLOT_W-1:0]   rd_data;

    logic                          rsp_valid_reg;
    mhrt_pkg::kind_t               kind_reg;
    logic [mhrt_pkg::OWNER_W-1:0]  owner_reg;
    logic [mhrt_pkg::POS_W-1:0]    index_reg;
    logic [mhrt_pkg::HANDLE_W-1:0] handle_reg;
    logic                          last_reg;

    mhrt_ram #(
        .WIDTH (mhrt_pkg::SLOT_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mhrt_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .out_free (out_free),
        .emit     (emit),
        .busy     (busy),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    // output register
    assign out_free = !rsp_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            kind_reg   <= emit.kind;
            owner_reg  <= emit.owner;
            index_reg  <= emit.index;
            handle_reg <= emit.handle;
            last_reg   <= emit.last;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.kind       = kind_reg;
    assign rsp.owner_out  = owner_reg;
    assign rsp.index_out  = index_reg;
    assign rsp.handle_out = handle_reg;
    assign rsp.last       = last_reg;

    `MHRT_ASSERT_NEXT(a_accept_busy, req.valid && req.ready, busy)
    `MHRT_ASSERT_NEXT(a_last_idle, emit.valid && emit.last, !busy && rsp.valid && rsp.last)
    `MHRT_ASSERT_SAME(a_err_clean, rsp.valid && rsp.kind == mhrt_pkg::KIND_ERROR, rsp.owner_out == '0 && rsp.index_out == '0 && rsp.handle_out == '0 && rsp.last)

endmodule

// ----- sim/tb_mru_handle_ring_table.sv -----
// self-checking testbench for the handle ring table: directed table, then random traffic
module tb_mru_handle_ring_table;
    timeunit 1ns;
    timeprecision 1ps;

    import mhrt_pkg::*;

    localparam int RING_DEPTH   = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 290;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = RING_DEPTH + 8;
    localparam int ROW_COUNT    = 20;

    typedef struct packed {
        kind_t               kind;
        logic [OWNER_W-1:0]  owner;
        logic [POS_W-1:0]    index;
        logic [HANDLE_W-1:0] handle;
        logic                last;
    } ring_result_t;

    typedef struct packed {
        op_t                 op;
        logic [POS_W-1:0]    pos;
        logic [HANDLE_W-1:0] handle;
        logic [OWNER_W-1:0]  owner;
        bit                  typed;
        ring_result_t        result;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    mhrt_req_if req_if();
    mhrt_rsp_if rsp_if();

    mru_handle_ring_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #10 clk = ~clk;

    // predictor state
    logic [HANDLE_W-1:0] ring_handle [RING_DEPTH];
    logic [OWNER_W-1:0]  ring_owner [RING_DEPTH];
    bit                  ring_live [RING_DEPTH];
    int unsigned         newest_slot;

    ring_result_t pending_results[$];
    ring_result_t step_results[$];
    stim_row_t    rows [ROW_COUNT];

    int error_count = 0;
    int cycle_count = 0;
    int stall_left;
    bit req_calm    = 1'b0;
    bit rsp_calm    = 1'b0;

    task automatic report(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int unsigned next_slot(int unsigned i);
        return (i + 1 >= RING_DEPTH) ? 0 : i + 1;
    endfunction

    function automatic void note(kind_t k, logic [OWNER_W-1:0] o, logic [POS_W-1:0] idx,
                                 logic [HANDLE_W-1:0] h);
        ring_result_t item;
        item = '{kind: k, owner: o, index: idx, handle: h, last: 1'b0};
        step_results.push_back(item);
    endfunction

    function automatic void predict_request(op_t op, logic [POS_W-1:0] pos,
                                            logic [HANDLE_W-1:0] h, logic [OWNER_W-1:0] o,
                                            bit enqueue);
        int unsigned         idx;
        int unsigned         nx;
        int unsigned         np;
        logic [HANDLE_W-1:0] sh;
        logic [OWNER_W-1:0]  so;
        bit                  sv;
        ring_result_t        tail;
        step_results.delete();
        if (op == OP_PUSH) begin
            np = next_slot(newest_slot);
            newest_slot = np;
            if (ring_live[np])
                note(KIND_UNLOADED, ring_owner[np], '0, '0);
            ring_handle[np] = h;
            ring_owner[np]  = o;
            ring_live[np]   = 1'b1;
            note(KIND_PLACED, o, POS_W'(np), '0);
        end
        else if (pos >= RING_DEPTH) begin
            note(KIND_ERROR, '0, '0, '0);
        end
        else if (op == OP_GET) begin
            note(KIND_HANDLE, '0, '0, ring_handle[pos]);
        end
        else if (op == OP_MOVE) begin
            np = newest_slot;
            if (pos != np) begin
                sh  = ring_handle[pos];
                so  = ring_owner[pos];
                sv  = ring_live[pos];
                idx = pos;
                while (idx != np) begin
                    nx = next_slot(idx);
                    ring_handle[idx] = ring_handle[nx];
                    ring_owner[idx]  = ring_owner[nx];
                    ring_live[idx]   = ring_live[nx];
                    if (ring_live[idx])
                        note(KIND_PLACED, ring_owner[idx], POS_W'(idx), '0);
                    idx = nx;
                end
                ring_handle[np] = sh;
                ring_owner[np]  = so;
                ring_live[np]   = sv;
                if (sv)
                    note(KIND_PLACED, so, POS_W'(np), '0);
            end
            note(KIND_HANDLE, '0, '0, ring_handle[np]);
        end
        else begin
            if (ring_live[pos])
                note(KIND_UNLOADED, ring_owner[pos], '0, '0);
            ring_handle[pos] = '0;
            ring_owner[pos]  = '0;
            ring_live[pos]   = 1'b0;
            note(KIND_ACK, '0, '0, '0);
        end
        tail = step_results.pop_back();
        tail.last = 1'b1;
        step_results.push_back(tail);
        if (enqueue)
            foreach (step_results[i])
                pending_results.push_back(step_results[i]);
    endfunction

    task automatic send_request(op_t op, logic [POS_W-1:0] pos, logic [HANDLE_W-1:0] h,
                                logic [OWNER_W-1:0] o);
        int gap;
        gap = pick_gap(req_calm);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.position  <= pos;
        req_if.handle_in <= h;
        req_if.owner_tag <= o;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
    endtask

    // response back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        int stall;
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            stall_left   <= 0;
        end
        else
        begin
            if ($urandom_range(0, 99) == 0)
                rsp_calm <= !rsp_calm;
            if (stall_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                stall = pick_gap(rsp_calm);
                rsp_if.ready <= (stall == 0);
                stall_left   <= (stall > 0) ? stall - 1 : 0;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // response checking
    always @(posedge clk)
    begin
        ring_result_t got;
        ring_result_t want;
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            got = '{kind: kind_t'(rsp_if.kind), owner: rsp_if.owner_out,
                    index: rsp_if.index_out, handle: rsp_if.handle_out, last: rsp_if.last};
            if (pending_results.size() == 0)
            begin
                report($sformatf("unexpected transaction kind=%0d owner=%h index=%0d handle=%h",
                                 got.kind, got.owner, got.index, got.handle));
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind || got.owner !== want.owner
                    || got.index !== want.index || got.handle !== want.handle
                    || got.last !== want.last)
                    report($sformatf("got k=%0d o=%h i=%0d h=%h l=%0b, want k=%0d o=%h i=%0d h=%h l=%0b",
                                     got.kind, got.owner, got.index, got.handle, got.last,
                                     want.kind, want.owner, want.index, want.handle, want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        op_t                 op;
        logic [POS_W-1:0]    pos;
        int                  r;

        rst_n            = 1'b0;
        req_if.valid     = 1'b0;
        req_if.operation = '0;
        req_if.position  = '0;
        req_if.handle_in = '0;
        req_if.owner_tag = '0;
        foreach (ring_live[i])
        begin
            ring_handle[i] = '0;
            ring_owner[i]  = '0;
            ring_live[i]   = 1'b0;
        end
        newest_slot = RING_DEPTH - 1;

        rows = '{
            '{OP_GET,    6'd0,  32'h0,        16'h0,    1'b1,
              '{KIND_HANDLE,   16'h0,    6'd0, 32'h0,        1'b1}},
            '{OP_GET,    6'd15, 32'h0,        16'h0,    1'b1,
              '{KIND_HANDLE,   16'h0,    6'd0, 32'h0,        1'b1}},
            '{OP_MOVE,   6'd15, 32'h0,        16'h0,    1'b1,
              '{KIND_HANDLE,   16'h0,    6'd0, 32'h0,        1'b1}},
            '{OP_REMOVE, 6'd3,  32'h0,        16'h0,    1'b1,
              '{KIND_ACK,      16'h0,    6'd0, 32'h0,        1'b1}},
            '{OP_GET,    6'd16, 32'hffffffff, 16'hffff, 1'b1,
              '{KIND_ERROR,    16'h0,    6'd0, 32'h0,        1'b1}},
            '{OP_MOVE,   6'd63, 32'h0,        16'h0,    1'b1,
              '{KIND_ERROR,    16'h0,    6'd0, 32'h0,        1'b1}},
            '{OP_REMOVE, 6'd40, 32'h0,        16'h0,    1'b1,
              '{KIND_ERROR,    16'h0,    6'd0, 32'h0,        1'b1}},
            '{OP_PUSH,   6'd63, 32'hffffffff, 16'hffff, 1'b1,
              '{KIND_PLACED,   16'hffff, 6'd0, 32'h0,        1'b1}},
            '{OP_PUSH,   6'd0,  32'h0,        16'h0,    1'b1,
              '{KIND_PLACED,   16'h0,    6'd1, 32'h0,        1'b1}},
            '{OP_PUSH,   6'd21, 32'h12345678, 16'ha5a5, 1'b1,
              '{KIND_PLACED,   16'ha5a5, 6'd2, 32'h0,        1'b1}},
            '{OP_GET,    6'd0,  32'h0,        16'h0,    1'b1,
              '{KIND_HANDLE,   16'h0,    6'd0, 32'hffffffff, 1'b1}},
            '{OP_MOVE,   6'd2,  32'h0,        16'h0,    1'b1,
              '{KIND_HANDLE,   16'h0,    6'd0, 32'h12345678, 1'b1}},
            '{OP_MOVE,   6'd0,  32'h0,        16'h0,    1'b0, '0},
            '{OP_MOVE,   6'd14, 32'h0,        16'h0,    1'b0, '0},
            '{OP_REMOVE, 6'd1,  32'h0,        16'h0,    1'b0, '0},
            '{OP_PUSH,   6'd5,  32'h55555555, 16'h5555, 1'b0, '0},
            '{OP_PUSH,   6'd0,  32'haaaaaaaa, 16'haaaa, 1'b0, '0},
            '{OP_MOVE,   6'd15, 32'h0,        16'h0,    1'b0, '0},
            '{OP_GET,    6'd63, 32'h0,        16'h0,    1'b1,
              '{KIND_ERROR,    16'h0,    6'd0, 32'h0,        1'b1}},
            '{OP_REMOVE, 6'd15, 32'h0,        16'h0,    1'b0, '0}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            send_request(rows[i].op, rows[i].pos, rows[i].handle, rows[i].owner);
            predict_request(rows[i].op, rows[i].pos, rows[i].handle, rows[i].owner,
                            !rows[i].typed);
            if (rows[i].typed)
                pending_results.push_back(rows[i].result);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(0, 39) == 0)
                req_calm = !req_calm;
            r  = $urandom_range(0, 99);
            op = (r < 35) ? OP_PUSH : (r < 60) ? OP_MOVE : (r < 80) ? OP_GET : OP_REMOVE;
            if ($urandom_range(0, 99) < 8)
                pos = POS_W'($urandom_range(RING_DEPTH, 63));
            else
                pos = POS_W'($urandom_range(0, RING_DEPTH - 1));
            send_request(op, pos, $urandom(), OWNER_W'($urandom()));
            predict_request(op, req_if.position, req_if.handle_in, req_if.owner_tag, 1'b1);
        end
        req_if.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/mhrt_pkg.sv
design/mhrt_req_if.sv
design/mhrt_rsp_if.sv
design/mhrt_ram.sv
design/mhrt_ctrl.sv
design/mru_handle_ring_table.sv
sim/tb_mru_handle_ring_table.sv
